/* src/hmtb_pkg.sv */
// Shared types and constants for the Hilbert move table builder.
// Used by hmtb_ctrl, hmtb_datapath and hilbert_move_table_builder; depends on nothing.
package hmtb_pkg;

    // Field widths fixed by the block's interface.
    localparam int LEVEL_W    = 4;
    localparam int IDX_W      = 14;
    localparam int BYTE_W     = 8;
    localparam int COORD_W    = 10;
    localparam int DIGIT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 2'd1;

    // Seed bytes for the two orientations.
    localparam logic [BYTE_W-1:0] SEED_ORIENT1 = 8'd27;
    localparam logic [BYTE_W-1:0] SEED_ORIENT0 = 8'd14;

    // Copy masks: full for ordinary bytes, reduced for the last byte of a block.
    localparam logic [BYTE_W-1:0] MASK_SIDE      = 8'd85;
    localparam logic [BYTE_W-1:0] MASK_TOP       = 8'd170;
    localparam logic [BYTE_W-1:0] MASK_SIDE_LAST = 8'd21;
    localparam logic [BYTE_W-1:0] MASK_TOP_LAST  = 8'd42;

    // Joining moves and the bit that each pass toggles in them.
    localparam logic [BYTE_W-1:0] JOIN_HI     = 8'd192;
    localparam logic [BYTE_W-1:0] JOIN_MID    = 8'd128;
    localparam logic [BYTE_W-1:0] JOIN_LO     = 8'd64;
    localparam logic [BYTE_W-1:0] JOIN_NONE   = 8'd0;
    localparam logic [BYTE_W-1:0] JOIN_TOGGLE = 8'd64;

    // Move codes.
    localparam logic [DIGIT_W-1:0] MOVE_COL_DEC = 2'd0;
    localparam logic [DIGIT_W-1:0] MOVE_ROW_DEC = 2'd1;
    localparam logic [DIGIT_W-1:0] MOVE_COL_INC = 2'd2;
    localparam logic [DIGIT_W-1:0] MOVE_ROW_INC = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_CHECK,
        ST_CP_RD,
        ST_CP_W1,
        ST_CP_W2,
        ST_CP_W3,
        ST_CP_W4,
        ST_WALK,
        ST_DRAIN,
        ST_BUILD_RESP,
        ST_READ_RESP
    } state_t;

    // Which table write the datapath performs.
    typedef enum logic [2:0] {
        WR_SEED,
        WR_COPY1,
        WR_COPY2,
        WR_COPY3,
        WR_JOIN
    } wr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    build_init;
        logic    read_issue;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    copy_rd;
        logic    c_next;
        logic    pass_next;
        logic    walk_init;
        logic    walk_rd;
        logic    resp_read;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic c_last;
        logic passes_done;
    } ctrl_sts_t;

endpackage

/* src/hmtb_ctrl.sv */
// Controller state machine for the Hilbert move table builder.
// Depends on hmtb_pkg for the state, command and status types.
module hmtb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               action,
    input  hmtb_pkg::ctrl_sts_t sts,
    output logic               busy,
    output logic               done,
    output hmtb_pkg::ctrl_cmd_t cmd
);

    hmtb_pkg::state_t state_reg;
    hmtb_pkg::state_t state_next;
    logic             accept;

    assign accept = start && (state_reg == hmtb_pkg::ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmtb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hmtb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = action ? hmtb_pkg::ST_READ_RESP : hmtb_pkg::ST_SEED;
                end
            end
            hmtb_pkg::ST_SEED:       state_next = hmtb_pkg::ST_CHECK;
            hmtb_pkg::ST_CHECK:
            begin
                state_next = sts.passes_done ? hmtb_pkg::ST_WALK : hmtb_pkg::ST_CP_RD;
            end
            hmtb_pkg::ST_CP_RD:      state_next = hmtb_pkg::ST_CP_W1;
            hmtb_pkg::ST_CP_W1:      state_next = hmtb_pkg::ST_CP_W2;
            hmtb_pkg::ST_CP_W2:      state_next = hmtb_pkg::ST_CP_W3;
            hmtb_pkg::ST_CP_W3:
            begin
                state_next = sts.c_last ? hmtb_pkg::ST_CP_W4 : hmtb_pkg::ST_CP_RD;
            end
            hmtb_pkg::ST_CP_W4:      state_next = hmtb_pkg::ST_CHECK;
            hmtb_pkg::ST_WALK:
            begin
                if (sts.c_last)
                begin
                    state_next = hmtb_pkg::ST_DRAIN;
                end
            end
            hmtb_pkg::ST_DRAIN:      state_next = hmtb_pkg::ST_BUILD_RESP;
            hmtb_pkg::ST_BUILD_RESP: state_next = hmtb_pkg::ST_IDLE;
            hmtb_pkg::ST_READ_RESP:  state_next = hmtb_pkg::ST_IDLE;
            default:                 state_next = hmtb_pkg::ST_IDLE;
        endcase
    end

    // Output and command decode.
    always_comb
    begin
        cmd        = '0;
        cmd.wr_sel = hmtb_pkg::WR_SEED;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            hmtb_pkg::ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.build_init = accept && !action;
                cmd.read_issue = accept && action;
            end
            hmtb_pkg::ST_SEED:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = hmtb_pkg::WR_SEED;
            end
            hmtb_pkg::ST_CHECK:
            begin
                cmd.walk_init = sts.passes_done;
            end
            hmtb_pkg::ST_CP_RD:
            begin
                cmd.copy_rd = 1'b1;
            end
            hmtb_pkg::ST_CP_W1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = hmtb_pkg::WR_COPY1;
            end
            hmtb_pkg::ST_CP_W2:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = hmtb_pkg::WR_COPY2;
            end
            hmtb_pkg::ST_CP_W3:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = hmtb_pkg::WR_COPY3;
                cmd.c_next = !sts.c_last;
            end
            hmtb_pkg::ST_CP_W4:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = hmtb_pkg::WR_JOIN;
                cmd.pass_next = 1'b1;
            end
            hmtb_pkg::ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                cmd.c_next  = 1'b1;
            end
            hmtb_pkg::ST_DRAIN:
            begin
                busy = 1'b1;
            end
            hmtb_pkg::ST_BUILD_RESP:
            begin
                done = 1'b1;
            end
            hmtb_pkg::ST_READ_RESP:
            begin
                done          = 1'b1;
                cmd.resp_read = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // A result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A table write never shares a cycle with a table read.
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !(cmd.copy_rd || cmd.walk_rd || cmd.read_issue))
        else $error("table read and write issued together");

    // The walk only runs after all doubling passes are done.
    a_walk_after_passes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_init |-> sts.passes_done)
        else $error("walk started before the table was complete");

endmodule

/* src/hmtb_datapath.sv */
// Datapath of the Hilbert move table builder: table memory, counters and walker.
// Depends on hmtb_pkg for constants and the command and status types.
module hmtb_datapath
#(
    parameter int MAX_LEVEL = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hmtb_pkg::ctrl_cmd_t                  cmd,
    output hmtb_pkg::ctrl_sts_t                  sts,
    input  logic [hmtb_pkg::LEVEL_W-1:0]         curve_level,
    input  logic                                 orientation,
    input  logic [hmtb_pkg::IDX_W-1:0]           byte_index,
    output logic [hmtb_pkg::BYTE_W-1:0]          move_byte,
    output logic                                 out_of_range,
    output logic signed [hmtb_pkg::COORD_W-1:0]  end_row,
    output logic signed [hmtb_pkg::COORD_W-1:0]  end_col,
    output logic [hmtb_pkg::DIGIT_W-1:0]         last_digit
);

    localparam int ADDR_W     = (MAX_LEVEL > 1) ? 2 * (MAX_LEVEL - 1) : 1;
    localparam int TABLE_SIZE = 1 << (2 * (MAX_LEVEL - 1));
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int CMP_W      = (SIZE_W > hmtb_pkg::IDX_W + 1) ? SIZE_W : hmtb_pkg::IDX_W + 1;
    localparam int BW         = hmtb_pkg::BYTE_W;
    localparam int LW         = hmtb_pkg::LEVEL_W;
    localparam int CW         = hmtb_pkg::COORD_W;

    // Table memory and its registered read data.
    logic [BW-1:0]     mem [TABLE_SIZE];
    logic [BW-1:0]     rdata_reg;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [BW-1:0]     wr_data;

    // Build control registers.
    logic [LW-1:0]     lvl_reg;
    logic [LW-1:0]     l_reg;
    logic              orient_reg;
    logic [SIZE_W-1:0] blk_reg;
    logic [ADDR_W-1:0] c_reg;
    logic [BW-1:0]     j1_reg;
    logic [BW-1:0]     j2_reg;
    logic [BW-1:0]     j3_reg;
    logic [SIZE_W-1:0] built_size_reg;
    logic              oor_reg;

    // Walk pipeline and results.
    logic              walk_vld_reg;
    logic              walk_lastb_reg;
    logic signed [CW-1:0] row_reg;
    logic signed [CW-1:0] col_reg;
    logic [hmtb_pkg::DIGIT_W-1:0] digit_reg;

    logic [LW-1:0]     lvl_eff;
    logic [SIZE_W-1:0] blk_m1;
    logic [SIZE_W:0]   blk_x;
    logic [SIZE_W:0]   c_x;
    logic [SIZE_W:0]   addr1;
    logic [SIZE_W:0]   addr2;
    logic [SIZE_W:0]   addr3;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  size_ext;
    logic [BW-1:0]     j1_tog;
    logic [BW-1:0]     j2_tog;
    logic [BW-1:0]     j3_tog;
    logic signed [3:0] d_row;
    logic signed [3:0] d_col;

    // Level clamp: zero counts as one, above the maximum saturates.
    always_comb
    begin
        if (curve_level == '0)
        begin
            lvl_eff = LW'(1);
        end
        else if (curve_level > LW'(MAX_LEVEL))
        begin
            lvl_eff = LW'(MAX_LEVEL);
        end
        else
        begin
            lvl_eff = curve_level;
        end
    end

    // Copy target addresses; blocks are powers of four so these never carry into c.
    assign blk_m1 = blk_reg - SIZE_W'(1);
    assign blk_x  = (SIZE_W + 1)'(blk_reg);
    assign c_x    = (SIZE_W + 1)'(c_reg);
    assign addr1  = c_x + blk_x;
    assign addr2  = c_x + (blk_x << 1);
    assign addr3  = c_x + (blk_x << 1) + blk_x;

    assign j1_tog = j1_reg ^ hmtb_pkg::JOIN_TOGGLE;
    assign j2_tog = j2_reg ^ hmtb_pkg::JOIN_TOGGLE;
    assign j3_tog = j3_reg ^ hmtb_pkg::JOIN_TOGGLE;

    assign sts.c_last      = (c_reg == blk_m1[ADDR_W-1:0]);
    assign sts.passes_done = (l_reg == lvl_reg);

    // Write address and data; the last byte's side copies fold in two joins, the join write the third.
    always_comb
    begin
        wr_addr = c_reg;
        wr_data = rdata_reg;
        case (cmd.wr_sel)
            hmtb_pkg::WR_SEED:
            begin
                wr_addr = '0;
                wr_data = orient_reg ? hmtb_pkg::SEED_ORIENT1 : hmtb_pkg::SEED_ORIENT0;
            end
            hmtb_pkg::WR_COPY1:
            begin
                wr_addr = addr1[ADDR_W-1:0];
                wr_data = sts.c_last ? ((rdata_reg ^ hmtb_pkg::MASK_SIDE_LAST) | j2_tog)
                                     : (rdata_reg ^ hmtb_pkg::MASK_SIDE);
            end
            hmtb_pkg::WR_COPY2:
            begin
                wr_addr = addr2[ADDR_W-1:0];
                wr_data = sts.c_last ? ((rdata_reg ^ hmtb_pkg::MASK_SIDE_LAST) | j3_tog)
                                     : (rdata_reg ^ hmtb_pkg::MASK_SIDE);
            end
            hmtb_pkg::WR_COPY3:
            begin
                wr_addr = addr3[ADDR_W-1:0];
                wr_data = sts.c_last ? (rdata_reg ^ hmtb_pkg::MASK_TOP_LAST)
                                     : (rdata_reg ^ hmtb_pkg::MASK_TOP);
            end
            hmtb_pkg::WR_JOIN:
            begin
                wr_addr = c_reg;
                wr_data = rdata_reg | j1_tog;
            end
            default:
            begin
                wr_addr = c_reg;
                wr_data = rdata_reg;
            end
        endcase
    end

    // Read address: the item's index for a read, the byte counter otherwise.
    assign idx_ext  = CMP_W'(byte_index);
    assign size_ext = CMP_W'(built_size_reg);
    assign mem_re   = cmd.read_issue || cmd.copy_rd || cmd.walk_rd;
    assign rd_addr  = cmd.read_issue ? idx_ext[ADDR_W-1:0] : c_reg;

    // Table memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Build counters and join registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg    <= LW'(1);
            l_reg      <= LW'(1);
            orient_reg <= 1'b0;
            blk_reg    <= SIZE_W'(1);
            c_reg      <= '0;
            j1_reg     <= hmtb_pkg::JOIN_MID;
            j2_reg     <= hmtb_pkg::JOIN_HI;
            j3_reg     <= hmtb_pkg::JOIN_NONE;
        end
        else if (cmd.build_init)
        begin
            lvl_reg    <= lvl_eff;
            l_reg      <= LW'(1);
            orient_reg <= orientation;
            blk_reg    <= SIZE_W'(1);
            c_reg      <= '0;
            j1_reg     <= orientation ? hmtb_pkg::JOIN_HI  : hmtb_pkg::JOIN_MID;
            j2_reg     <= orientation ? hmtb_pkg::JOIN_MID : hmtb_pkg::JOIN_HI;
            j3_reg     <= orientation ? hmtb_pkg::JOIN_LO  : hmtb_pkg::JOIN_NONE;
        end
        else if (cmd.pass_next)
        begin
            l_reg   <= l_reg + LW'(1);
            blk_reg <= blk_reg << 2;
            c_reg   <= '0;
            j1_reg  <= j1_tog;
            j2_reg  <= j2_tog;
            j3_reg  <= j3_tog;
        end
        else if (cmd.walk_init)
        begin
            c_reg <= '0;
        end
        else if (cmd.c_next)
        begin
            c_reg <= c_reg + ADDR_W'(1);
        end
    end

    // Net displacement of one byte: four moves, or three on the final byte.
    always_comb
    begin
        d_row = '0;
        d_col = '0;
        for (int k = 0; k < 4; k++)
        begin
            if ((k < 3) || !walk_lastb_reg)
            begin
                case (rdata_reg[2*k +: 2])
                    hmtb_pkg::MOVE_COL_DEC: d_col = d_col - 4'sd1;
                    hmtb_pkg::MOVE_ROW_DEC: d_row = d_row - 4'sd1;
                    hmtb_pkg::MOVE_COL_INC: d_col = d_col + 4'sd1;
                    hmtb_pkg::MOVE_ROW_INC: d_row = d_row + 4'sd1;
                    default:                d_row = d_row;
                endcase
            end
        end
    end

    // Walk accumulator, table size and read range flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_vld_reg   <= 1'b0;
            walk_lastb_reg <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            digit_reg      <= '0;
            built_size_reg <= '0;
            oor_reg        <= 1'b0;
        end
        else
        begin
            walk_vld_reg   <= cmd.walk_rd;
            walk_lastb_reg <= cmd.walk_rd && sts.c_last;
            if (cmd.walk_init)
            begin
                row_reg        <= '0;
                col_reg        <= '0;
                digit_reg      <= '0;
                built_size_reg <= blk_reg;
            end
            else if (walk_vld_reg)
            begin
                row_reg   <= row_reg + CW'(d_row);
                col_reg   <= col_reg + CW'(d_col);
                digit_reg <= walk_lastb_reg ? rdata_reg[5:4] : rdata_reg[7:6];
            end
            if (cmd.read_issue)
            begin
                oor_reg <= !(idx_ext < size_ext);
            end
        end
    end

    // Result fields; a build reports a zero byte and a clear flag.
    assign move_byte    = (cmd.resp_read && !oor_reg) ? rdata_reg : '0;
    assign out_of_range = cmd.resp_read && oor_reg;
    assign end_row      = row_reg;
    assign end_col      = col_reg;
    assign last_digit   = digit_reg;

endmodule

/* src/hilbert_move_table_builder.sv */
// Hilbert move table builder: a read returns its result in the cycle after acceptance,
// and no next item is accepted until the block is back in idle after the result. A build
// seeds the table, then for each pass copies every byte with a read and three writes and
// adds a join write and a check; the walk then reads one byte per cycle.
// Results cannot be stalled by the receiver.
// Reset is asynchronous, active low; the table contents are undefined until a build.
module hilbert_move_table_builder
#(
    parameter int MAX_LEVEL = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output logic                                   done,
    input  logic                                   action,
    input  logic [hmtb_pkg::IDX_W-1:0]             byte_index,
    output logic [hmtb_pkg::BYTE_W-1:0]            move_byte,
    output logic                                   out_of_range,
    output logic signed [hmtb_pkg::COORD_W-1:0]    end_row,
    output logic signed [hmtb_pkg::COORD_W-1:0]    end_col,
    output logic [hmtb_pkg::DIGIT_W-1:0]           last_digit,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hmtb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hmtb_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [hmtb_pkg::LEVEL_W-1:0] curve_level_reg;
    logic                         orientation_reg;
    hmtb_pkg::ctrl_cmd_t          cmd;
    hmtb_pkg::ctrl_sts_t          sts;

    // Configuration registers; every write transaction completes at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_level_reg <= hmtb_pkg::LEVEL_W'(1);
            orientation_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hmtb_pkg::CFG_CURVE_LEVEL: curve_level_reg <= cfg_data;
                hmtb_pkg::CFG_ORIENTATION: orientation_reg <= cfg_data[0];
                default:                   orientation_reg <= orientation_reg;
            endcase
        end
    end

    // Controller.
    hmtb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    // Datapath with the table memory.
    hmtb_datapath
    #(
        .MAX_LEVEL (MAX_LEVEL)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .curve_level  (curve_level_reg),
        .orientation  (orientation_reg),
        .byte_index   (byte_index),
        .move_byte    (move_byte),
        .out_of_range (out_of_range),
        .end_row      (end_row),
        .end_col      (end_col),
        .last_digit   (last_digit)
    );

endmodule
